// ===== src/pdfa_pkg.sv =====
// shared constants, types and helpers for the page directory frame allocator
package pdfa_pkg;

  // table sizes
  localparam int DIR_ENTRIES = 1024;
  localparam int FRAME_COUNT = 1024;

  // field widths
  localparam int REQ_W    = 2;
  localparam int PAGE_W   = 10;
  localparam int FRAME_W  = 10;
  localparam int FLAG_W   = 8;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 32;

  // directory entry layout
  localparam int FRAME_SHIFT = 22;
  localparam logic [ENTRY_W-1:0] ENTRY_BASE_FLAGS = 32'h0000_0083;
  localparam int PRESENT_BIT = 0;

  // directory memory geometry
  localparam int DIR_AW = $clog2(DIR_ENTRIES);

  // bitmap memory geometry: one word holds the used bits of BMP_W frames
  localparam int BMP_W     = 32;
  localparam int BIT_W     = $clog2(BMP_W);
  localparam int BMP_WORDS = (FRAME_COUNT + BMP_W - 1) / BMP_W;
  localparam int BMP_DEPTH = (BMP_WORDS < 2) ? 2 : BMP_WORDS;
  localparam int WORD_AW   = $clog2(BMP_DEPTH);

  // clearing pass after reset covers both memories
  localparam int CLR_N = (DIR_ENTRIES > BMP_DEPTH) ? DIR_ENTRIES : BMP_DEPTH;
  localparam int CLR_W = $clog2(CLR_N);

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // command to the bitmap word unit
  typedef struct packed {
    logic               set;
    logic [WORD_AW-1:0] word_idx;
    logic [BIT_W-1:0]   bit_pos;
  } word_cmd_t;

  // lowest clear bit found in one bitmap word
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] bit_pos;
  } scan_res_t;

  // frame may be handed out by find-free: not frame 0 and inside the bitmap
  function automatic logic frame_ok(input logic [WORD_AW-1:0] idx,
                                    input logic [BIT_W-1:0] bit_pos);
    logic [WORD_AW+BIT_W-1:0] f;
    f = {idx, bit_pos};
    return (f != '0) && (32'(f) < 32'(FRAME_COUNT));
  endfunction

  function automatic logic frame_in_range(input logic [FRAME_W-1:0] f);
    return 32'(f) < 32'(FRAME_COUNT);
  endfunction

  function automatic logic page_in_range(input logic [PAGE_W-1:0] p);
    return 32'(p) < 32'(DIR_ENTRIES);
  endfunction

endpackage

// ===== src/pdfa_ram.sv =====
// simple dual port ram with registered read data
module pdfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pdfa_word_unit.sv =====
// shared bitmap word unit: set or clear one bit, find lowest free frame bit
module pdfa_word_unit (
  input  logic [pdfa_pkg::BMP_W-1:0] word,
  input  pdfa_pkg::word_cmd_t        cmd,
  output logic [pdfa_pkg::BMP_W-1:0] new_word,
  output pdfa_pkg::scan_res_t        scan
);

  logic [pdfa_pkg::BMP_W-1:0] sel;

  // single bit update
  assign sel      = pdfa_pkg::BMP_W'(1) << cmd.bit_pos;
  assign new_word = cmd.set ? (word | sel) : (word & ~sel);

  // priority search, lowest clear bit wins
  always_comb begin
    scan.hit     = 1'b0;
    scan.bit_pos = '0;
    for (int b = pdfa_pkg::BMP_W - 1; b >= 0; b--) begin
      if (!word[b] && pdfa_pkg::frame_ok(cmd.word_idx, pdfa_pkg::BIT_W'(b))) begin
        scan.hit     = 1'b1;
        scan.bit_pos = pdfa_pkg::BIT_W'(b);
      end
    end
  end

endmodule

// ===== src/page_directory_frame_allocator.sv =====
// top level: page directory table, frame bitmap and request sequencer
//
// Keeps a table of 4 MB page directory entries and a used bitmap of physical
// frames, both in on-chip ram. After reset a clearing pass zeroes both rams,
// one address per cycle across CLR_N addresses (1024 by default), and
// in_ready stays low during it. One item is handled at a time: in_ready is
// high only while the sequencer is idle. An add goes through a lookup and an
// apply step, a remove through lookup, apply and, when a frame is freed, a
// free step, and an unknown request goes straight to the result. Find-free
// reads and checks one 32-bit bitmap word at a time until a free frame turns
// up (up to 32 words), since the bitmap ram has a single read port and the
// one shared word unit checks one word per read.
// A finished result waits in an output register, so the next item can be
// taken while it is still pending.
module page_directory_frame_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pdfa_pkg::REQ_W-1:0]    req_type,
  input  logic [pdfa_pkg::PAGE_W-1:0]   virt_page,
  input  logic [pdfa_pkg::FRAME_W-1:0]  phys_frame,
  input  logic [pdfa_pkg::FLAG_W-1:0]   extra_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pdfa_pkg::STATUS_W-1:0] status,
  output logic [pdfa_pkg::ENTRY_W-1:0]  entry_word,
  output logic [pdfa_pkg::FRAME_W-1:0]  free_frame
);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_LOOKUP   = 8'b0000_0100,
    S_APPLY    = 8'b0000_1000,
    S_FREE     = 8'b0001_0000,
    S_SCAN_RD  = 8'b0010_0000,
    S_SCAN_CHK = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state;

  // captured request
  pdfa_pkg::req_t                 req;
  logic [pdfa_pkg::PAGE_W-1:0]    vp;
  logic [pdfa_pkg::FRAME_W-1:0]   pf;
  logic [pdfa_pkg::FLAG_W-1:0]    fl;

  // sequencer bookkeeping
  logic [pdfa_pkg::CLR_W-1:0]     clr_cnt;
  logic [pdfa_pkg::WORD_AW-1:0]   scan_idx;
  logic [pdfa_pkg::WORD_AW-1:0]   free_idx;
  logic [pdfa_pkg::BIT_W-1:0]     free_bit;

  // pending result and output register
  pdfa_pkg::status_t              res_status;
  logic [pdfa_pkg::ENTRY_W-1:0]   res_word;
  logic [pdfa_pkg::FRAME_W-1:0]   res_frame;
  pdfa_pkg::status_t              out_status;
  logic [pdfa_pkg::ENTRY_W-1:0]   out_word;
  logic [pdfa_pkg::FRAME_W-1:0]   out_frame;

  // ram ports
  logic                           dir_we;
  logic [pdfa_pkg::DIR_AW-1:0]    dir_waddr;
  logic [pdfa_pkg::ENTRY_W-1:0]   dir_wdata;
  logic                           dir_re;
  logic [pdfa_pkg::ENTRY_W-1:0]   dir_rdata;
  logic                           bmp_we;
  logic [pdfa_pkg::WORD_AW-1:0]   bmp_waddr;
  logic [pdfa_pkg::BMP_W-1:0]     bmp_wdata;
  logic                           bmp_re;
  logic [pdfa_pkg::WORD_AW-1:0]   bmp_raddr;
  logic [pdfa_pkg::BMP_W-1:0]     bmp_rdata;

  // word unit
  pdfa_pkg::word_cmd_t            wcmd;
  logic [pdfa_pkg::BMP_W-1:0]     new_word;
  pdfa_pkg::scan_res_t            scan;

  // derived values
  logic [pdfa_pkg::DIR_AW-1:0]    vp_addr;
  logic [pdfa_pkg::WORD_AW-1:0]   pf_word;
  logic [pdfa_pkg::ENTRY_W-1:0]   add_word;
  logic [pdfa_pkg::FRAME_W-1:0]   old_frame;
  logic                           old_present;
  logic                           in_take;
  logic                           out_free;
  logic                           clr_last;

  assign vp_addr     = vp[pdfa_pkg::DIR_AW-1:0];
  assign pf_word     = pf[pdfa_pkg::BIT_W +: pdfa_pkg::WORD_AW];
  assign add_word    = (pdfa_pkg::ENTRY_W'(pf) << pdfa_pkg::FRAME_SHIFT)
                       | pdfa_pkg::ENTRY_BASE_FLAGS | pdfa_pkg::ENTRY_W'(fl);
  assign old_frame   = dir_rdata[pdfa_pkg::FRAME_SHIFT +: pdfa_pkg::FRAME_W];
  assign old_present = dir_rdata[pdfa_pkg::PRESENT_BIT];
  assign in_ready    = (state == S_IDLE);
  assign in_take     = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign clr_last    = (clr_cnt == pdfa_pkg::CLR_W'(pdfa_pkg::CLR_N - 1));

  assign status      = out_status;
  assign entry_word  = out_word;
  assign free_frame  = out_frame;

  // word unit command follows the sequencer step
  always_comb begin
    unique case (state)
      S_APPLY: begin
        wcmd.set      = 1'b1;
        wcmd.word_idx = pf_word;
        wcmd.bit_pos  = pf[pdfa_pkg::BIT_W-1:0];
      end
      S_FREE: begin
        wcmd.set      = 1'b0;
        wcmd.word_idx = free_idx;
        wcmd.bit_pos  = free_bit;
      end
      default: begin
        wcmd.set      = 1'b0;
        wcmd.word_idx = scan_idx;
        wcmd.bit_pos  = '0;
      end
    endcase
  end

  pdfa_word_unit u_word (
    .word     (bmp_rdata),
    .cmd      (wcmd),
    .new_word (new_word),
    .scan     (scan)
  );

  // ram control
  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = vp_addr;
    dir_wdata = '0;
    dir_re    = 1'b0;
    bmp_we    = 1'b0;
    bmp_waddr = wcmd.word_idx;
    bmp_wdata = new_word;
    bmp_re    = 1'b0;
    bmp_raddr = pf_word;
    unique case (state)
      S_CLEAR: begin
        dir_waddr = clr_cnt[pdfa_pkg::DIR_AW-1:0];
        dir_we    = 32'(clr_cnt) < 32'(pdfa_pkg::DIR_ENTRIES);
        bmp_waddr = clr_cnt[pdfa_pkg::WORD_AW-1:0];
        bmp_wdata = '0;
        bmp_we    = 32'(clr_cnt) < 32'(pdfa_pkg::BMP_DEPTH);
      end
      S_LOOKUP: begin
        dir_re = 1'b1;
        bmp_re = 1'b1;
      end
      S_APPLY: begin
        if (req == pdfa_pkg::REQ_ADD) begin
          if (!old_present) begin
            dir_we    = 1'b1;
            dir_wdata = add_word;
            bmp_we    = pdfa_pkg::frame_in_range(pf);
          end
        end else begin
          dir_we    = 1'b1;
          bmp_raddr = old_frame[pdfa_pkg::BIT_W +: pdfa_pkg::WORD_AW];
          bmp_re    = old_present && pdfa_pkg::frame_in_range(old_frame);
        end
      end
      S_FREE: begin
        bmp_we = 1'b1;
      end
      S_SCAN_RD: begin
        bmp_raddr = scan_idx;
        bmp_re    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  pdfa_ram #(
    .WIDTH (pdfa_pkg::ENTRY_W),
    .DEPTH (pdfa_pkg::DIR_ENTRIES)
  ) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (vp_addr),
    .rdata (dir_rdata)
  );

  pdfa_ram #(
    .WIDTH (pdfa_pkg::BMP_W),
    .DEPTH (pdfa_pkg::BMP_DEPTH)
  ) u_bmp (
    .clk   (clk),
    .we    (bmp_we),
    .waddr (bmp_waddr),
    .wdata (bmp_wdata),
    .re    (bmp_re),
    .raddr (bmp_raddr),
    .rdata (bmp_rdata)
  );

  // request capture, never reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      req <= pdfa_pkg::req_t'(req_type);
      vp  <= virt_page;
      pf  <= phys_frame;
      fl  <= extra_flags;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            res_status <= pdfa_pkg::ST_OK;
            res_word   <= '0;
            res_frame  <= '0;
            scan_idx   <= '0;
            case (pdfa_pkg::req_t'(req_type))
              pdfa_pkg::REQ_ADD, pdfa_pkg::REQ_REMOVE: begin
                state <= pdfa_pkg::page_in_range(virt_page) ? S_LOOKUP : S_DONE;
              end
              pdfa_pkg::REQ_FIND: state <= S_SCAN_RD;
              default:            state <= S_DONE;
            endcase
          end
        end
        S_LOOKUP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          free_idx <= old_frame[pdfa_pkg::BIT_W +: pdfa_pkg::WORD_AW];
          free_bit <= old_frame[pdfa_pkg::BIT_W-1:0];
          if (req == pdfa_pkg::REQ_ADD) begin
            if (old_present) begin
              res_status <= pdfa_pkg::ST_PRESENT;
            end else begin
              res_word <= add_word;
            end
            state <= S_DONE;
          end else if (old_present && pdfa_pkg::frame_in_range(old_frame)) begin
            state <= S_FREE;
          end else begin
            state <= S_DONE;
          end
        end
        S_FREE: begin
          state <= S_DONE;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (scan.hit) begin
            res_frame <= pdfa_pkg::FRAME_W'({scan_idx, scan.bit_pos});
            state     <= S_DONE;
          end else if (scan_idx == pdfa_pkg::WORD_AW'(pdfa_pkg::BMP_WORDS - 1)) begin
            res_status <= pdfa_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_status <= res_status;
      out_word   <= res_word;
      out_frame  <= res_frame;
    end
  end

endmodule

// ===== src/pdfa_checker.sv =====
// port level checks for the page directory frame allocator, bound to the top
module pdfa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pdfa_pkg::STATUS_W-1:0] status,
  input logic [pdfa_pkg::ENTRY_W-1:0]  entry_word,
  input logic [pdfa_pkg::FRAME_W-1:0]  free_frame
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(entry_word) && $stable(free_frame))
    else $error("result changed while stalled");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == pdfa_pkg::ST_OK) || (status == pdfa_pkg::ST_PRESENT)
      || (status == pdfa_pkg::ST_FULL))
    else $error("undefined status code");

  // failed requests carry no entry and no frame
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == pdfa_pkg::ST_PRESENT) || (status == pdfa_pkg::ST_FULL))
      |-> entry_word == '0 && free_frame == '0)
    else $error("failed request carries data");

  // a written entry is present, writable and a large page
  a_entry_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_word != '0 |-> entry_word[7] && entry_word[1]
      && entry_word[0] && free_frame == '0)
    else $error("malformed directory entry");

  // taking an input item drops in_ready, so items are never taken back to back
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken before the first finished");

endmodule

bind page_directory_frame_allocator pdfa_checker u_pdfa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .entry_word (entry_word),
  .free_frame (free_frame)
);

// ===== test/testbench.sv =====
// self-checking testbench for the page directory frame allocator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 100;

  // predicted directory and frame bitmap, plus the replies still owed
  class directory_scoreboard;
    typedef struct {
      pdfa_pkg::status_t                  st;
      logic [pdfa_pkg::ENTRY_W-1:0]       word;
      logic [pdfa_pkg::FRAME_W-1:0]       frame;
    } reply_t;

    reply_t                       expected_replies[$];
    logic [pdfa_pkg::ENTRY_W-1:0] dir_words [pdfa_pkg::DIR_ENTRIES];
    bit                           frame_taken [pdfa_pkg::FRAME_COUNT];
    int                           mismatches;

    function new();
      mismatches = 0;
      foreach (dir_words[i]) dir_words[i] = '0;
      foreach (frame_taken[i]) frame_taken[i] = 1'b0;
    endfunction

    task report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // update the predicted tables for one accepted item and queue its reply
    function void note_request(input pdfa_pkg::req_t req,
                               input logic [pdfa_pkg::PAGE_W-1:0] vp,
                               input logic [pdfa_pkg::FRAME_W-1:0] pf,
                               input logic [pdfa_pkg::FLAG_W-1:0] fl);
      reply_t                       r;
      logic [pdfa_pkg::ENTRY_W-1:0] held;
      int                           fr;
      r.st    = pdfa_pkg::ST_OK;
      r.word  = '0;
      r.frame = '0;
      case (req)
        pdfa_pkg::REQ_ADD: begin
          if (int'(vp) < pdfa_pkg::DIR_ENTRIES) begin
            if (dir_words[vp][pdfa_pkg::PRESENT_BIT]) begin
              r.st = pdfa_pkg::ST_PRESENT;
            end else begin
              r.word = (pdfa_pkg::ENTRY_W'(pf) << pdfa_pkg::FRAME_SHIFT)
                       | pdfa_pkg::ENTRY_BASE_FLAGS | pdfa_pkg::ENTRY_W'(fl);
              dir_words[vp] = r.word;
              if (int'(pf) < pdfa_pkg::FRAME_COUNT) frame_taken[pf] = 1'b1;
            end
          end
        end
        pdfa_pkg::REQ_REMOVE: begin
          if (int'(vp) < pdfa_pkg::DIR_ENTRIES) begin
            held = dir_words[vp];
            if (held[pdfa_pkg::PRESENT_BIT]) begin
              fr = int'(held >> pdfa_pkg::FRAME_SHIFT);
              if (fr < pdfa_pkg::FRAME_COUNT) frame_taken[fr] = 1'b0;
            end
            dir_words[vp] = '0;
          end
        end
        pdfa_pkg::REQ_FIND: begin
          // lowest clear frame, frame 0 never handed out
          r.st = pdfa_pkg::ST_FULL;
          for (int i = 1; i < pdfa_pkg::FRAME_COUNT; i++) begin
            if (!frame_taken[i]) begin
              r.st    = pdfa_pkg::ST_OK;
              r.frame = pdfa_pkg::FRAME_W'(i);
              break;
            end
          end
        end
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    // compare one accepted result with the oldest expected reply
    task check_result(input logic [pdfa_pkg::STATUS_W-1:0] st,
                      input logic [pdfa_pkg::ENTRY_W-1:0] w,
                      input logic [pdfa_pkg::FRAME_W-1:0] f);
      reply_t e;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected item status=%0d entry=%h frame=%0d",
                                  st, w, f));
        return;
      end
      e = expected_replies.pop_front();
      if (st !== e.st)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.st));
      if (w !== e.word)
        report_mismatch($sformatf("entry_word %h, expected %h", w, e.word));
      if (f !== e.frame)
        report_mismatch($sformatf("free_frame %0d, expected %0d", f, e.frame));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [pdfa_pkg::REQ_W-1:0]    req_type;
  logic [pdfa_pkg::PAGE_W-1:0]   virt_page;
  logic [pdfa_pkg::FRAME_W-1:0]  phys_frame;
  logic [pdfa_pkg::FLAG_W-1:0]   extra_flags;
  logic                          out_valid;
  logic                          out_ready;
  logic [pdfa_pkg::STATUS_W-1:0] status;
  logic [pdfa_pkg::ENTRY_W-1:0]  entry_word;
  logic [pdfa_pkg::FRAME_W-1:0]  free_frame;

  directory_scoreboard sb;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int cycle_count     = 0;

  page_directory_frame_allocator DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .virt_page   (virt_page),
    .phys_frame  (phys_frame),
    .extra_flags (extra_flags),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_word  (entry_word),
    .free_frame  (free_frame)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: check accepted items, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(status, entry_word, free_frame);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // present one item, optionally after an idle gap, and wait for acceptance
  task automatic send_request(input pdfa_pkg::req_t r,
                              input logic [pdfa_pkg::PAGE_W-1:0] vp,
                              input logic [pdfa_pkg::FRAME_W-1:0] pf,
                              input logic [pdfa_pkg::FLAG_W-1:0] fl);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid    <= 1'b1;
    req_type    <= r;
    virt_page   <= vp;
    phys_frame  <= pf;
    extra_flags <= fl;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r, vp, pf, fl);
  endtask

  // random page that is mapped or unmapped as asked, -1 if none
  function automatic int find_page(input bit want_mapped);
    int start;
    int p;
    start = $urandom_range(pdfa_pkg::DIR_ENTRIES - 1);
    for (int k = 0; k < pdfa_pkg::DIR_ENTRIES; k++) begin
      p = (start + k) % pdfa_pkg::DIR_ENTRIES;
      if (sb.dir_words[p][pdfa_pkg::PRESENT_BIT] == want_mapped) return p;
    end
    return -1;
  endfunction

  // random clear frame other than frame 0, -1 if none
  function automatic int find_open_frame();
    int start;
    int f;
    start = $urandom_range(pdfa_pkg::FRAME_COUNT - 2);
    for (int k = 0; k < pdfa_pkg::FRAME_COUNT - 1; k++) begin
      f = 1 + (start + k) % (pdfa_pkg::FRAME_COUNT - 1);
      if (!sb.frame_taken[f]) return f;
    end
    return -1;
  endfunction

  function automatic logic [pdfa_pkg::PAGE_W-1:0] any_page();
    return pdfa_pkg::PAGE_W'($urandom_range(pdfa_pkg::DIR_ENTRIES - 1));
  endfunction

  function automatic logic [pdfa_pkg::FRAME_W-1:0] any_frame();
    return pdfa_pkg::FRAME_W'($urandom_range(pdfa_pkg::FRAME_COUNT - 1));
  endfunction

  function automatic logic [pdfa_pkg::FLAG_W-1:0] any_flags();
    return pdfa_pkg::FLAG_W'($urandom_range(255));
  endfunction

  // mostly well-formed add, remove and find, with some noise
  task automatic send_mixed_item();
    int pick;
    int p;
    int f;
    pick = $urandom_range(99);
    if (pick < 30) begin
      p = find_page(1'b0);
      f = ($urandom_range(3) == 0) ? int'(any_frame()) : find_open_frame();
      if (p < 0) p = any_page();
      if (f < 0) f = any_frame();
      send_request(pdfa_pkg::REQ_ADD, pdfa_pkg::PAGE_W'(p), pdfa_pkg::FRAME_W'(f),
                   any_flags());
    end else if (pick < 50) begin
      p = find_page(1'b1);
      if (p < 0) p = any_page();
      send_request(pdfa_pkg::REQ_REMOVE, pdfa_pkg::PAGE_W'(p), any_frame(), any_flags());
    end else if (pick < 75) begin
      send_request(pdfa_pkg::REQ_FIND, any_page(), any_frame(), any_flags());
    end else if (pick < 83) begin
      send_request(pdfa_pkg::REQ_NONE, any_page(), any_frame(), any_flags());
    end else if (pick < 90) begin
      send_request(pdfa_pkg::REQ_ADD, any_page(), any_frame(), any_flags());
    end else if (pick < 97) begin
      send_request(pdfa_pkg::REQ_REMOVE, any_page(), any_frame(), any_flags());
    end else begin
      send_request(pdfa_pkg::REQ_ADD, any_page(), '0, any_flags());
    end
  endtask

  // map every frame until find-free reports memory full, then poke the full state
  task automatic fill_frames();
    int p;
    int f;
    int guard;
    guard = 0;
    f = find_open_frame();
    while (f >= 0 && guard < 1500) begin
      p = find_page(1'b0);
      if (p < 0) begin
        p = find_page(1'b1);
        send_request(pdfa_pkg::REQ_REMOVE, pdfa_pkg::PAGE_W'(p), any_frame(),
                     any_flags());
      end else begin
        send_request(pdfa_pkg::REQ_ADD, pdfa_pkg::PAGE_W'(p), pdfa_pkg::FRAME_W'(f),
                     any_flags());
      end
      if ($urandom_range(7) == 0)
        send_request(pdfa_pkg::REQ_FIND, any_page(), any_frame(), any_flags());
      guard++;
      f = find_open_frame();
    end
    repeat (4) send_request(pdfa_pkg::REQ_FIND, any_page(), any_frame(), any_flags());
    repeat (3) begin
      p = find_page(1'b1);
      if (p < 0) p = any_page();
      send_request(pdfa_pkg::REQ_ADD, pdfa_pkg::PAGE_W'(p), any_frame(), any_flags());
    end
  endtask

  // directed items: field extremes, every request and the corner cases
  task automatic run_directed();
    send_request(pdfa_pkg::REQ_FIND, '0, '0, '0);
    send_request(pdfa_pkg::REQ_ADD, 10'd0, 10'd0, 8'h00);
    send_request(pdfa_pkg::REQ_FIND, '1, '1, '1);
    send_request(pdfa_pkg::REQ_ADD, 10'd1023, 10'd1023, 8'hFF);
    // already mapped
    send_request(pdfa_pkg::REQ_ADD, 10'd1023, 10'd5, 8'h10);
    send_request(pdfa_pkg::REQ_ADD, 10'd1, 10'd1, 8'h00);
    send_request(pdfa_pkg::REQ_FIND, 10'h2AA, 10'h155, 8'h55);
    send_request(pdfa_pkg::REQ_REMOVE, 10'd1, 10'd0, 8'h00);
    send_request(pdfa_pkg::REQ_FIND, '0, '0, '0);
    // remove of an absent entry
    send_request(pdfa_pkg::REQ_REMOVE, 10'd1, '1, '1);
    send_request(pdfa_pkg::REQ_REMOVE, 10'd5, 10'd5, 8'h00);
    // unknown request
    send_request(pdfa_pkg::REQ_NONE, '1, '1, '1);
    send_request(pdfa_pkg::REQ_NONE, '0, '0, '0);
    // two pages sharing one frame
    send_request(pdfa_pkg::REQ_ADD, 10'd2, 10'd1, 8'h7C);
    send_request(pdfa_pkg::REQ_ADD, 10'd3, 10'd1, 8'h01);
    send_request(pdfa_pkg::REQ_REMOVE, 10'd2, 10'd0, 8'h00);
    send_request(pdfa_pkg::REQ_FIND, '0, '0, '0);
    send_request(pdfa_pkg::REQ_REMOVE, 10'd1023, 10'd0, 8'h00);
    send_request(pdfa_pkg::REQ_ADD, 10'h200, 10'h200, 8'hAA);
    send_request(pdfa_pkg::REQ_ADD, 10'h155, 10'h2AA, 8'h55);
    send_request(pdfa_pkg::REQ_FIND, '0, '0, '0);
    send_request(pdfa_pkg::REQ_REMOVE, 10'd0, 10'd0, 8'h00);
    send_request(pdfa_pkg::REQ_FIND, '0, '0, '0);
    send_request(pdfa_pkg::REQ_REMOVE, 10'd3, 10'd0, 8'h00);
    send_request(pdfa_pkg::REQ_FIND, '0, '0, '0);
  endtask

  // reset, stimulus phases, drain and verdict
  initial begin
    sb = new();
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    req_type    <= '0;
    virt_page   <= '0;
    phys_frame  <= '0;
    extra_flags <= '0;
    out_ready   <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // no idling
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (200) send_mixed_item();

    // sparse sender
    sender_idle_pct = 86;
    recv_stall_pct  = 0;
    repeat (200) send_mixed_item();

    // slow receiver while the bitmap fills up
    sender_idle_pct = 0;
    recv_stall_pct  = 86;
    fill_frames();

    // light idling on both sides
    sender_idle_pct = 16;
    recv_stall_pct  = 16;
    repeat (150) send_mixed_item();

    in_valid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
